### rtl/uv_sphere_vertex_generator_defines.svh
// Assertion helpers used by the checker of this block.
`ifndef UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH

// Clocked assertion that is masked while reset is held.
`define USV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also covers the reset cycles.
`define USV_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/usv_pkg.sv
package usv_pkg;

    localparam int CNT_W      = 9;
    localparam int MAX_STACKS = 256;
    localparam int MAX_SLICES = 256;

    // Reciprocal 2^RCP_K / count, rounded up; exact floor for numerators below 2^27.
    localparam int RCP_K   = 36;
    localparam int RCP_W   = RCP_K + 1;
    localparam int RCP_LO  = 18;
    localparam int NUM_W   = 27;
    localparam int STEP_W  = 6;

    localparam int ANG_W   = 18;
    localparam int RED_W   = 17;
    localparam int COEF_W  = 31;
    localparam int LANE_DEPTH = 6;

    localparam logic [COEF_W-1:0] SIN_C1 = 31'd1686629713;
    localparam logic [COEF_W-1:0] SIN_C3 = 31'd693598668;
    localparam logic [COEF_W-1:0] SIN_C5 = 31'd85569306;
    localparam logic [COEF_W-1:0] SIN_C7 = 31'd5026995;
    localparam logic [COEF_W-1:0] SIN_C9 = 31'd172272;
    localparam logic [15:0]       ONE_Q14 = 16'd16384;

    localparam logic REG_STACKS = 1'b0;
    localparam logic REG_SLICES = 1'b1;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] stacks;
        logic [CNT_W-1:0] slices;
        logic [RCP_W-1:0] rcp_st;
        logic [RCP_W-1:0] rcp_sl;
    } t_cfg;

endpackage

### rtl/uv_sphere_vertex_generator.sv
// One vertex per clock sustained while the output is not stalled and no reciprocal pass runs.
// The pipeline is the reciprocal multiply (3 stages), quadrant fold,
// six stages of the sine polynomial per lane, and the Q14 product/output register.
// Reset (synchronous, active low) loads 16 stacks and 32 slices, then the reciprocal
// unit runs its pass with s_axis_tready low; every register write repeats that pass.
module uv_sphere_vertex_generator import usv_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write channel: index 0 stacks_in_use, 1 slices_in_use
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [8:0]   i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [8:0] lat_index, [17:9] lon_index, [23:18] zero
    input  logic [23:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] normal_x, [31:16] normal_y, [47:32] normal_z, [63:48] tangent_x,
    // [79:64] tangent_z, [95:80] bitangent_x, [111:96] bitangent_y,
    // [127:112] bitangent_z, [143:128] tex_u, [159:144] tex_v,
    // [176:160] vertex_number, [183:177] zero
    output logic [183:0] m_axis_tdata
);

    typedef struct packed {
        logic [15:0] tu;
        logic [15:0] tv;
        logic [16:0] vn;
    } t_aux;

    function automatic logic signed [15:0] mul_q14(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        logic [15:0] ma, mb, m;
        logic [31:0] p;
        ma = a[15] ? 16'(-a) : a;
        mb = b[15] ? 16'(-b) : b;
        p  = 32'(ma) * 32'(mb) + 32'd8192;
        m  = p[29:14];
        return (a[15] ^ b[15]) ? -$signed(m) : $signed(m);
    endfunction

    t_cfg cfg;
    logic en, take;

    // The whole pipe advances together; a held output stalls every stage.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en && !cfg.busy;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    usv_recip u_recip (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // ---------------- stage A: saturate, build rounded numerators
    logic [8:0] lat_in, lon_in, lat_s, lon_s;
    logic       r_va, r_vb, r_vc, r_vd, r_vk;
    logic [NUM_W-1:0] r_n_th, r_n_ph, r_n_tu, r_n_tv;
    logic [16:0] r_vn_a;
    logic [18:0] vn_prod;

    always_comb begin
        lat_in  = s_axis_tdata[8:0];
        lon_in  = s_axis_tdata[17:9];
        lat_s   = (lat_in > cfg.stacks) ? cfg.stacks : lat_in;
        lon_s   = (lon_in > cfg.slices) ? cfg.slices : lon_in;
        vn_prod = 19'(lat_s) * 19'({1'b0, cfg.slices} + 10'd1) + 19'(lon_s);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_th <= NUM_W'({lat_s, 17'b0}) + NUM_W'(cfg.stacks >> 1);
            r_n_ph <= NUM_W'({lon_s, 18'b0}) + NUM_W'(cfg.slices >> 1);
            r_n_tu <= NUM_W'({lon_s, 15'b0}) + NUM_W'(cfg.slices >> 1);
            r_n_tv <= NUM_W'({lat_s, 15'b0}) + NUM_W'(cfg.stacks >> 1);
            r_vn_a <= vn_prod[16:0];
        end
    end

    // ---------------- stage B: partial products against the reciprocals
    localparam int HI_W = RCP_W - RCP_LO;
    logic [NUM_W+RCP_LO-1:0] r_lo [4];
    logic [NUM_W+HI_W-1:0]   r_hi [4];
    logic [16:0] r_vn_b;
    logic [NUM_W-1:0] num [4];
    logic [RCP_W-1:0] rcp [4];

    always_comb begin
        num[0] = r_n_th; rcp[0] = cfg.rcp_st;
        num[1] = r_n_ph; rcp[1] = cfg.rcp_sl;
        num[2] = r_n_tu; rcp[2] = cfg.rcp_sl;
        num[3] = r_n_tv; rcp[3] = cfg.rcp_st;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_lo[i] <= (NUM_W+RCP_LO)'(num[i]) * (NUM_W+RCP_LO)'(rcp[i][RCP_LO-1:0]);
                r_hi[i] <= (NUM_W+HI_W)'(num[i]) * (NUM_W+HI_W)'(rcp[i][RCP_W-1:RCP_LO]);
            end
            r_vn_b <= r_vn_a;
        end
    end

    // ---------------- stage C: sum partial products, keep the quotients
    logic [ANG_W-1:0] r_theta, r_phi;
    logic [15:0] r_tu_c, r_tv_c;
    logic [16:0] r_vn_c;
    logic [NUM_W+RCP_W-1:0] full [4];

    always_comb begin
        for (int i = 0; i < 4; i++)
            full[i] = ((NUM_W+RCP_W)'(r_hi[i]) << RCP_LO) + (NUM_W+RCP_W)'(r_lo[i]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_theta <= full[0][RCP_K+ANG_W-1:RCP_K];
            r_phi   <= full[1][RCP_K+ANG_W-1:RCP_K];   // full turn wraps to zero
            r_tu_c  <= full[2][RCP_K+15:RCP_K];
            r_tv_c  <= full[3][RCP_K+15:RCP_K];
            r_vn_c  <= r_vn_b;
        end
    end

    // ---------------- stage D: fold each angle into a quarter turn
    logic [ANG_W-1:0] ang [4];
    logic [RED_W-1:0] red [4];
    logic [RED_W-1:0] r_red [4];
    logic             r_neg [4];
    logic             fneg [4];
    t_aux r_aux_d;

    always_comb begin
        ang[0] = r_theta;                          // sin theta
        ang[1] = ANG_W'(r_theta + 18'd65536);      // cos theta
        ang[2] = r_phi;                            // sin phi
        ang[3] = ANG_W'(r_phi + 18'd65536);        // cos phi
        for (int i = 0; i < 4; i++) begin
            red[i]  = {1'b0, ang[i][15:0]};
            if (ang[i][16]) red[i] = RED_W'(17'd65536 - red[i]);
            fneg[i] = ang[i][17];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_red[i] <= red[i];
                r_neg[i] <= fneg[i];
            end
            r_aux_d <= '{tu: r_tu_c, tv: r_tv_c, vn: r_vn_c};
        end
    end

    // ---------------- sine lanes (six stages each)
    logic signed [15:0] trig [4];

    for (genvar g = 0; g < 4; g++) begin : g_lane
        usv_sin u_sin (
            .i_clk (i_clk),
            .i_en  (en),
            .i_r   (r_red[g]),
            .i_neg (r_neg[g]),
            .o_val (trig[g])
        );
    end

    t_aux r_aux [LANE_DEPTH];
    logic [LANE_DEPTH-1:0] r_vl;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_aux[0] <= r_aux_d;
            for (int i = 1; i < LANE_DEPTH; i++) r_aux[i] <= r_aux[i-1];
        end
    end

    // ---------------- stage K: Q14 products and the output register
    logic [176:0] r_out;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= {r_aux[LANE_DEPTH-1].vn, r_aux[LANE_DEPTH-1].tv,
                      r_aux[LANE_DEPTH-1].tu,
                      mul_q14(trig[1], trig[2]),   // bitangent z
                      -trig[0],                    // bitangent y
                      mul_q14(trig[1], trig[3]),   // bitangent x
                      trig[3],                     // tangent z
                      -trig[2],                    // tangent x
                      mul_q14(trig[0], trig[2]),   // normal z
                      trig[1],                     // normal y
                      mul_q14(trig[0], trig[3])};  // normal x
        end
    end

    // Valid bits ride along with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_vl <= '0;
            r_vk <= 1'b0;
        end else if (en) begin
            r_va <= take;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_vl <= {r_vl[LANE_DEPTH-2:0], r_vd};
            r_vk <= r_vl[LANE_DEPTH-1];
        end
    end

    assign m_axis_tvalid = r_vk;
    assign m_axis_tdata  = {7'b0, r_out};

endmodule

### rtl/usv_recip.sv
module usv_recip import usv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic             i_wr_index,
    input  logic [CNT_W-1:0] i_wr_data,
    output t_cfg             o_cfg
);

    logic [CNT_W-1:0]  r_stacks, r_slices, n_stacks, n_slices;
    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_rem_st, r_rem_sl, n_rem_st, n_rem_sl;
    logic [RCP_K-1:0]  r_q_st, r_q_sl, n_q_st, n_q_sl;
    logic [RCP_W-1:0]  r_rcp_st, r_rcp_sl, n_rcp_st, n_rcp_sl;
    logic [CNT_W-1:0]  clamped;
    logic [CNT_W:0]    sh_st, sh_sl;
    logic              ge_st, ge_sl;

    always_comb begin
        clamped = i_wr_data;
        if (clamped == '0) clamped = CNT_W'(1);
        if (i_wr_index == REG_STACKS && clamped > CNT_W'(MAX_STACKS))
            clamped = CNT_W'(MAX_STACKS);
        if (i_wr_index == REG_SLICES && clamped > CNT_W'(MAX_SLICES))
            clamped = CNT_W'(MAX_SLICES);
    end

    // One quotient bit of (2^K - 1) / count per cycle for each register.
    always_comb begin
        sh_st = {r_rem_st, 1'b1};
        sh_sl = {r_rem_sl, 1'b1};
        ge_st = sh_st >= {1'b0, r_stacks};
        ge_sl = sh_sl >= {1'b0, r_slices};
        n_rem_st = ge_st ? CNT_W'(sh_st - {1'b0, r_stacks}) : sh_st[CNT_W-1:0];
        n_rem_sl = ge_sl ? CNT_W'(sh_sl - {1'b0, r_slices}) : sh_sl[CNT_W-1:0];
        n_q_st = {r_q_st[RCP_K-2:0], ge_st};
        n_q_sl = {r_q_sl[RCP_K-2:0], ge_sl};
        n_rcp_st = r_rcp_st;
        n_rcp_sl = r_rcp_sl;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_stacks = r_stacks;
        n_slices = r_slices;
        if (r_busy) begin
            n_cnt = STEP_W'(r_cnt + 1'b1);
            if (r_cnt == STEP_W'(RCP_K - 1)) begin
                n_busy = 1'b0;
                n_rcp_st = RCP_W'({1'b0, n_q_st} + 1'b1);
                n_rcp_sl = RCP_W'({1'b0, n_q_sl} + 1'b1);
            end
        end
        if (i_wr) begin
            if (i_wr_index == REG_STACKS) n_stacks = clamped;
            else n_slices = clamped;
            n_busy = 1'b1;
            n_cnt = '0;
            n_rem_st = '0;
            n_rem_sl = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stacks <= CNT_W'(16);
            r_slices <= CNT_W'(32);
            r_busy   <= 1'b1;
            r_cnt    <= '0;
            r_rem_st <= '0;
            r_rem_sl <= '0;
        end else begin
            r_stacks <= n_stacks;
            r_slices <= n_slices;
            r_busy   <= n_busy;
            r_cnt    <= n_cnt;
            r_rem_st <= n_rem_st;
            r_rem_sl <= n_rem_sl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_st   <= n_q_st;
        r_q_sl   <= n_q_sl;
        r_rcp_st <= n_rcp_st;
        r_rcp_sl <= n_rcp_sl;
    end

    assign o_cfg = '{busy: r_busy, stacks: r_stacks, slices: r_slices,
                     rcp_st: r_rcp_st, rcp_sl: r_rcp_sl};

endmodule

### rtl/usv_sin.sv
module usv_sin import usv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [RED_W-1:0]  i_r,
    input  logic              i_neg,
    output logic signed [15:0] o_val
);

    logic [RED_W-1:0]  r_r   [LANE_DEPTH-1];
    logic              r_neg [LANE_DEPTH-1];
    logic [COEF_W-1:0] r_q2  [LANE_DEPTH-2];
    logic [COEF_W-1:0] r_t   [LANE_DEPTH-2];
    logic signed [15:0] r_out;

    logic [2*RED_W-1:0]  sq;
    logic [2*COEF_W-1:0] p9, p7, p5, p3;
    logic [47:0]         pf;
    logic [15:0]         mag;

    always_comb begin
        sq  = (2*RED_W)'(i_r) * (2*RED_W)'(i_r) + (2*RED_W)'(2);
        p9  = (2*COEF_W)'(SIN_C9) * (2*COEF_W)'(r_q2[0]);
        p7  = (2*COEF_W)'(r_t[0]) * (2*COEF_W)'(r_q2[1]);
        p5  = (2*COEF_W)'(r_t[1]) * (2*COEF_W)'(r_q2[2]);
        p3  = (2*COEF_W)'(r_t[2]) * (2*COEF_W)'(r_q2[3]);
        pf  = 48'(r_t[3]) * 48'(r_r[LANE_DEPTH-2]) + 48'h8000_0000;
        mag = (pf[47:32] > ONE_Q14) ? ONE_Q14 : pf[47:32];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0]   <= i_r;
            r_neg[0] <= i_neg;
            for (int i = 1; i < LANE_DEPTH-1; i++) begin
                r_r[i]   <= r_r[i-1];
                r_neg[i] <= r_neg[i-1];
            end
            r_q2[0] <= COEF_W'(sq >> 2);
            for (int i = 1; i < LANE_DEPTH-2; i++) r_q2[i] <= r_q2[i-1];
            r_t[0] <= COEF_W'(SIN_C7 - COEF_W'(p9 >> 30));
            r_t[1] <= COEF_W'(SIN_C5 - COEF_W'(p7 >> 30));
            r_t[2] <= COEF_W'(SIN_C3 - COEF_W'(p5 >> 30));
            r_t[3] <= COEF_W'(SIN_C1 - COEF_W'(p3 >> 30));
            r_out  <= r_neg[LANE_DEPTH-2] ? -$signed(mag) : $signed(mag);
        end
    end

    assign o_val = r_out;

endmodule

### rtl/usv_checker.sv
`include "uv_sphere_vertex_generator_defines.svh"

module usv_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_cfg_valid,
    input logic         o_cfg_ready,
    input logic         i_cfg_index,
    input logic [8:0]   i_cfg_data,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [23:0]  s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [183:0] m_axis_tdata
);

    `USV_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output valid dropped while stalled")
    `USV_ASSERT_RST(a_rst_busy, !i_rst_n |=> !s_axis_tready, "input taken before reciprocals ready")
    `USV_ASSERT(a_cfg_busy, i_cfg_valid && o_cfg_ready |=> !s_axis_tready, "input taken during reciprocal pass")
    `USV_ASSERT(a_stall_in, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while pipe stalled")

endmodule

bind uv_sphere_vertex_generator usv_checker u_usv_checker (.*);
